// ----- sv/mrc_pkg.sv -----
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants of the read holding registers response checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

    localparam int DEF_MAX_FRAME_LEN = 256;

    localparam int BYTE_W     = 8;
    localparam int CNT_REG_W  = 7;
    localparam int STATUS_W   = 3;
    localparam int LEN_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CRC_W      = 16;
    localparam int HDR_LEN    = 3;

    localparam logic [CRC_W-1:0]     CRC_INIT       = 16'hFFFF;
    localparam logic [CRC_W-1:0]     CRC_POLY       = 16'hA001;
    localparam logic [BYTE_W-1:0]    FUNC_READ_HOLD = 8'h03;
    localparam int                   FUNC_EXC_BIT   = 7;
    localparam logic [LEN_W-1:0]     EXC_FRAME_LEN  = 9'd5;
    localparam logic [BYTE_W-1:0]    DEF_SLAVE      = 8'd1;
    localparam logic [CNT_REG_W-1:0] DEF_COUNT      = 7'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_LENGTH    = 3'd1,
        ST_SLAVE     = 3'd2,
        ST_FUNCTION  = 3'd3,
        ST_BYTECOUNT = 3'd4,
        ST_CRC       = 3'd5,
        ST_EXCEPTION = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE = 1'b0,
        CFG_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eof;
    } t_in_item;

endpackage

`default_nettype wire

// ----- sv/mrc_in_stage.sv -----
// ----------------------------------------------------------------------------
// mrc_in_stage
// Input register: holds one received byte until the frame checker takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_in_stage (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [mrc_pkg::BYTE_W-1:0] i_frame_byte,
    input  wire logic                       i_end_of_frame,
    input  wire logic                       i_take,
    output logic                            o_valid,
    output mrc_pkg::t_in_item               o_item
);
    import mrc_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // held item waits while the checker cannot take it
    assign o_in_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.data <= i_frame_byte;
            r_item.eof  <= i_end_of_frame;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- sv/mrc_frame_chk.sv -----
// ----------------------------------------------------------------------------
// mrc_frame_chk
// Per-frame state (crc, length, header, trailer) and the status register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_frame_chk #(
    parameter int MAX_FRAME_LEN = mrc_pkg::DEF_MAX_FRAME_LEN
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire mrc_pkg::t_in_item             i_item,
    output logic                               o_take,
    input  wire logic [mrc_pkg::BYTE_W-1:0]    i_exp_slave,
    input  wire logic [mrc_pkg::CNT_REG_W-1:0] i_exp_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [mrc_pkg::STATUS_W-1:0]       o_status
);
    import mrc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_LEN + 1);

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [CW-1:0]     r_count, n_count;
    logic [BYTE_W-1:0] r_hdr   [HDR_LEN];
    logic [BYTE_W-1:0] n_hdr   [HDR_LEN];
    logic [BYTE_W-1:0] r_trail [2];
    logic [BYTE_W-1:0] n_trail [2];
    logic              r_out_valid;
    t_status           r_status, n_status;

    logic              out_free;
    logic [LEN_W-1:0]  len_old, len_new, want_len;
    logic [BYTE_W-1:0] want_bytes;
    logic [CRC_W-1:0]  rcvd_crc;

    assign out_free = !r_out_valid || !i_out_stall;
    // a last byte needs the status register free, others always go
    assign o_take   = i_valid && (!i_item.eof || out_free);

    assign len_old = LEN_W'(r_count);

    always_comb begin
        n_crc = (len_old >= LEN_W'(2)) ? crc_feed(r_crc, r_trail[0]) : r_crc;
        n_trail[0] = r_trail[1];
        n_trail[1] = i_item.data;
        for (int i = 0; i < HDR_LEN; i++) begin
            n_hdr[i] = (len_old == LEN_W'(i)) ? i_item.data : r_hdr[i];
        end
        n_count = (r_count < CW'(MAX_FRAME_LEN)) ? r_count + CW'(1) : r_count;
    end

    assign len_new    = LEN_W'(n_count);
    assign want_bytes = {i_exp_count, 1'b0};
    assign want_len   = LEN_W'(want_bytes) + EXC_FRAME_LEN;
    assign rcvd_crc   = {n_trail[1], n_trail[0]};

    always_comb begin
        if (len_new == EXC_FRAME_LEN && n_hdr[0] == i_exp_slave &&
            n_hdr[1][FUNC_EXC_BIT]) begin
            n_status = (rcvd_crc != n_crc) ? ST_CRC : ST_EXCEPTION;
        end else if (len_new != want_len) begin
            n_status = ST_LENGTH;
        end else if (n_hdr[0] != i_exp_slave) begin
            n_status = ST_SLAVE;
        end else if (n_hdr[1] != FUNC_READ_HOLD) begin
            n_status = ST_FUNCTION;
        end else if (n_hdr[2] != want_bytes) begin
            n_status = ST_BYTECOUNT;
        end else if (rcvd_crc != n_crc) begin
            n_status = ST_CRC;
        end else begin
            n_status = ST_OK;
        end
    end

    // frame state returns to its start values after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_item.eof)) begin
            r_crc   <= CRC_INIT;
            r_count <= '0;
            for (int i = 0; i < HDR_LEN; i++) begin
                r_hdr[i] <= '0;
            end
            r_trail[0] <= '0;
            r_trail[1] <= '0;
        end else if (o_take) begin
            r_crc   <= n_crc;
            r_count <= n_count;
            for (int i = 0; i < HDR_LEN; i++) begin
                r_hdr[i] <= n_hdr[i];
            end
            r_trail[0] <= n_trail[0];
            r_trail[1] <= n_trail[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_take && i_item.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && o_take && i_item.eof) begin
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

endmodule

`default_nettype wire

// ----- sv/modbus_read_response_checker.sv -----
// status is registered: the last byte of a frame passes the input register, then the status register
// throughput: one byte per cycle; input stalls only while a held byte marks the
// end of a frame and the previous status has not been taken
// crc, length, header and trailer are updated for each byte that the checker takes
// reset: expected slave and expected count go to 1, frame state is cleared
// ----------------------------------------------------------------------------
// modbus_read_response_checker
// Checks a Modbus RTU read holding registers response frame, byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_read_response_checker #(
    parameter int MAX_FRAME_LEN = mrc_pkg::DEF_MAX_FRAME_LEN
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [mrc_pkg::BYTE_W-1:0]    i_frame_byte,
    input  wire logic                          i_end_of_frame,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [mrc_pkg::STATUS_W-1:0]       o_status,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mrc_pkg::BYTE_W-1:0]    i_cfg_data
);
    import mrc_pkg::*;

    logic [BYTE_W-1:0]    r_exp_slave;
    logic [CNT_REG_W-1:0] r_exp_count;
    logic                 s1_valid;
    logic                 s1_take;
    t_in_item             s1_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_slave <= DEF_SLAVE;
            r_exp_count <= DEF_COUNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SLAVE: r_exp_slave <= i_cfg_data;
                CFG_COUNT: r_exp_count <= i_cfg_data[CNT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    mrc_in_stage u_in_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_frame_byte   (i_frame_byte),
        .i_end_of_frame (i_end_of_frame),
        .i_take         (s1_take),
        .o_valid        (s1_valid),
        .o_item         (s1_item)
    );

    mrc_frame_chk #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_frame_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_item      (s1_item),
        .o_take      (s1_take),
        .i_exp_slave (r_exp_slave),
        .i_exp_count (r_exp_count),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

// ----- bench/modbus_read_response_checker_tb.sv -----
// ----------------------------------------------------------------------------
// modbus_read_response_checker_tb
// Feeds whole response frames byte by byte, both well-formed and corrupted,
// and compares every status with a cycle-free model kept in a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_read_response_checker_tb;

    import mrc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_BYTES = 100;

    typedef enum int {
        FK_GOOD,
        FK_EXC,
        FK_EXC_BAD_CRC,
        FK_BAD_SLAVE,
        FK_BAD_FUNC,
        FK_BAD_BCNT,
        FK_BAD_CRC,
        FK_BAD_LEN,
        FK_SHORT,
        FK_NOISE
    } t_frame_kind;

    class resp_status_model;
        logic [BYTE_W-1:0]    exp_slave;
        logic [CNT_REG_W-1:0] exp_count;
        logic [CRC_W-1:0]     crc_acc;
        logic [LEN_W-1:0]     len_cnt;
        logic [BYTE_W-1:0]    hdr[HDR_LEN];
        logic [BYTE_W-1:0]    tail[2];
        t_status              status_due[$];
        int                   errors;

        function new();
            exp_slave = DEF_SLAVE;
            exp_count = DEF_COUNT;
            errors    = 0;
            clear_frame();
        endfunction

        static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc,
                                                   logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] c;
            c = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++) begin
                if (c[0])
                    c = (c >> 1) ^ CRC_POLY;
                else
                    c = c >> 1;
            end
            return c;
        endfunction

        function void clear_frame();
            crc_acc = CRC_INIT;
            len_cnt = '0;
            foreach (hdr[k]) hdr[k] = '0;
            tail[0] = '0;
            tail[1] = '0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [BYTE_W-1:0] val);
            if (idx == CFG_SLAVE)
                exp_slave = val;
            else
                exp_count = val[CNT_REG_W-1:0];
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        // one accepted byte; on the last byte of a frame the status is queued
        function void take_byte(logic [BYTE_W-1:0] b, logic eof);
            logic [CRC_W-1:0] rx_crc;
            int               want_len;
            t_status          st;
            // the byte leaving the two-byte window is covered by the crc
            if (len_cnt >= 2)
                crc_acc = crc_step(crc_acc, tail[0]);
            tail[0] = tail[1];
            tail[1] = b;
            if (len_cnt < HDR_LEN)
                hdr[len_cnt] = b;
            if (len_cnt < DEF_MAX_FRAME_LEN)
                len_cnt = len_cnt + 1'b1;
            if (!eof)
                return;
            rx_crc   = {tail[1], tail[0]};
            want_len = 5 + 2 * int'(exp_count);
            if (len_cnt == EXC_FRAME_LEN && hdr[0] == exp_slave && hdr[1][FUNC_EXC_BIT])
                st = (rx_crc != crc_acc) ? ST_CRC : ST_EXCEPTION;
            else if (int'(len_cnt) != want_len)
                st = ST_LENGTH;
            else if (hdr[0] != exp_slave)
                st = ST_SLAVE;
            else if (hdr[1] != FUNC_READ_HOLD)
                st = ST_FUNCTION;
            else if (hdr[2] != {exp_count, 1'b0})
                st = ST_BYTECOUNT;
            else if (rx_crc != crc_acc)
                st = ST_CRC;
            else
                st = ST_OK;
            status_due.push_back(st);
            clear_frame();
        endfunction

        function void check_status(logic [STATUS_W-1:0] got);
            t_status want;
            if (status_due.size() == 0) begin
                $display("%0t: status %0d with no frame outstanding", $time, got);
                errors++;
                return;
            end
            want = status_due.pop_front();
            if (got !== want) begin
                $display("%0t: status mismatch, expected %0d (%s), got %0d",
                         $time, want, want.name(), got);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic [BYTE_W-1:0]    i_frame_byte   = '0;
    logic                 i_end_of_frame = 1'b0;
    logic                 i_out_stall    = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [BYTE_W-1:0]    i_cfg_data     = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_cfg_ready;

    resp_status_model sb;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    int               sent_bytes    = 0;
    int               idle_cycles   = 0;

    modbus_read_response_checker DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_frame_byte   (i_frame_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stall, status check and watchdog
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_status(o_status);
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_frame_byte   <= b;
        i_end_of_frame <= eof;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.take_byte(b, eof);
        sent_bytes++;
    endtask

    task automatic wait_for_status_drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [BYTE_W-1:0] val);
        wait_for_status_drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input t_frame_kind kind);
        logic [BYTE_W-1:0] frm[$];
        logic [BYTE_W-1:0] slv;
        logic [BYTE_W-1:0] bc;
        logic [BYTE_W-1:0] fn;
        logic [CRC_W-1:0]  crc;
        int                n;
        slv = sb.exp_slave;
        bc  = {sb.exp_count, 1'b0};
        case (kind)
            FK_EXC, FK_EXC_BAD_CRC: begin
                frm.push_back(slv);
                frm.push_back(8'($urandom_range(128, 255)));
                frm.push_back(8'($urandom));
            end
            FK_SHORT, FK_NOISE: begin
                n = (kind == FK_SHORT) ? $urandom_range(1, 4) : $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    frm.push_back(8'($urandom));
                if ($urandom_range(1))
                    frm[0] = slv;
            end
            default: begin
                fn = FUNC_READ_HOLD;
                if (kind == FK_BAD_FUNC) begin
                    fn = 8'($urandom);
                    if (fn == FUNC_READ_HOLD)
                        fn = 8'h83;
                end
                frm.push_back(kind == FK_BAD_SLAVE ? slv + 8'($urandom_range(1, 255)) : slv);
                frm.push_back(fn);
                frm.push_back(kind == FK_BAD_BCNT ? bc ^ 8'($urandom_range(1, 255)) : bc);
                for (int i = 0; i < 2 * int'(sb.exp_count); i++)
                    frm.push_back(8'($urandom));
                if (kind == FK_BAD_LEN) begin
                    if ($urandom_range(1))
                        void'(frm.pop_back());
                    else
                        frm.push_back(8'($urandom));
                end
            end
        endcase
        if (kind != FK_SHORT && kind != FK_NOISE) begin
            crc = CRC_INIT;
            foreach (frm[i])
                crc = resp_status_model::crc_step(crc, frm[i]);
            if (kind == FK_BAD_CRC || kind == FK_EXC_BAD_CRC)
                crc = crc ^ (16'h0001 << $urandom_range(15));
            frm.push_back(crc[7:0]);
            frm.push_back(crc[15:8]);
        end
        foreach (frm[i])
            send_byte(frm[i], i == frm.size() - 1);
    endtask

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 40) return FK_GOOD;
        if (r < 48) return FK_EXC;
        if (r < 52) return FK_EXC_BAD_CRC;
        if (r < 58) return FK_BAD_SLAVE;
        if (r < 64) return FK_BAD_FUNC;
        if (r < 70) return FK_BAD_BCNT;
        if (r < 78) return FK_BAD_CRC;
        if (r < 84) return FK_BAD_LEN;
        if (r < 90) return FK_SHORT;
        return FK_NOISE;
    endfunction

    task automatic random_frames(input int idle, input int stall);
        int target;
        send_idle_pct = idle;
        stall_pct     = stall;
        target        = sent_bytes + PHASE_BYTES;
        while (sent_bytes < target) begin
            send_frame(pick_kind());
            if ($urandom_range(19) == 0)
                wait_for_status_drain();
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: slave 1, one register
        send_frame(FK_GOOD);
        send_frame(FK_EXC);
        send_frame(FK_EXC_BAD_CRC);
        send_frame(FK_BAD_FUNC);
        send_frame(FK_SHORT);

        write_reg(CFG_SLAVE, 8'h00);
        write_reg(CFG_COUNT, 8'h00);
        random_frames(0, 0);

        write_reg(CFG_SLAVE, 8'hFF);
        write_reg(CFG_COUNT, 8'h03);
        random_frames(65, 0);

        write_reg(CFG_SLAVE, 8'($urandom));
        write_reg(CFG_COUNT, 8'($urandom_range(1, 6)));
        random_frames(0, 65);

        // bit 7 of the count write is dropped by the register
        write_reg(CFG_SLAVE, 8'($urandom));
        write_reg(CFG_COUNT, 8'h82);
        random_frames(24, 24);

        // a count whose frame overruns the length counter
        write_reg(CFG_COUNT, 8'hFF);
        send_frame(FK_GOOD);
        send_frame(FK_EXC);

        wait_for_status_drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- modbus_read_response_checker.f -----
sv/mrc_pkg.sv
sv/mrc_in_stage.sv
sv/mrc_frame_chk.sv
sv/modbus_read_response_checker.sv
bench/modbus_read_response_checker_tb.sv
